[rtl/core/solve_3x3_cramer_defines.svh]
// Assertion macros for the solver's top level.
`ifndef SOLVE_3X3_CRAMER_DEFINES_SVH
`define SOLVE_3X3_CRAMER_DEFINES_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define SC3_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside reset.
`define SC3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/sc3_pkg.sv]
// Shared constants and types of the 3x3 Cramer's rule solver.
package sc3_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int TOL_W          = 48;
    localparam int CFG_IDX_W      = 1;
    localparam int N_ENTRIES      = 9;
    localparam int N_UNK          = 3;
    localparam int N_LANES        = N_UNK + 1;
    localparam int DET_LAT        = 4;

    localparam logic             TOL_EN_RST   = 1'b1;
    localparam logic [TOL_W-1:0] TOL_FRAC_RST = TOL_W'(281);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOL_ENABLE   = 1'b0,
        CFG_TOL_FRACTION = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic neg;
        logic sing;
    } t_div_ctl;

endpackage

[rtl/core/sc3_det_lane.sv]
// One determinant lane: pipelined exact 3x3 determinant by cofactor expansion.
module sc3_det_lane #(
    parameter int DATA_WIDTH = sc3_pkg::DATA_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [DATA_WIDTH-1:0]   i_a [sc3_pkg::N_ENTRIES],
    output logic signed [3*DATA_WIDTH+2:0] o_det
);

    localparam int P2W = 2 * DATA_WIDTH;
    localparam int TW  = P2W + 1;
    localparam int DW  = 3 * DATA_WIDTH + 3;

    logic signed [P2W-1:0]        r_p [6];
    logic signed [P2W-1:0]        n_p [6];
    logic signed [DATA_WIDTH-1:0] r_top_a [3];
    logic signed [DATA_WIDTH-1:0] r_top_b [3];
    logic signed [TW-1:0]         r_t [3];
    logic signed [TW-1:0]         n_t [3];
    logic signed [TW-1:0]         r_pl [3];
    logic signed [TW-1:0]         n_pl [3];
    logic signed [TW-1:0]         r_ph [3];
    logic signed [TW-1:0]         n_ph [3];
    logic signed [DW-1:0]         v_c [3];
    logic signed [DW-1:0]         r_det;
    logic signed [DW-1:0]         n_det;

    always_comb begin
        n_p[0] = P2W'(i_a[4]) * P2W'(i_a[8]);
        n_p[1] = P2W'(i_a[5]) * P2W'(i_a[7]);
        n_p[2] = P2W'(i_a[3]) * P2W'(i_a[8]);
        n_p[3] = P2W'(i_a[5]) * P2W'(i_a[6]);
        n_p[4] = P2W'(i_a[3]) * P2W'(i_a[7]);
        n_p[5] = P2W'(i_a[4]) * P2W'(i_a[6]);
        for (int i = 0; i < 3; i++) begin
            n_t[i] = TW'(r_p[2*i]) - TW'(r_p[2*i+1]);
            // The cofactor is split into a low unsigned word and a signed high part.
            n_pl[i] = TW'(r_top_b[i]) * TW'($signed({1'b0, r_t[i][DATA_WIDTH-1:0]}));
            n_ph[i] = TW'(r_top_b[i]) * TW'($signed(r_t[i][TW-1:DATA_WIDTH]));
            v_c[i]  = (DW'(r_ph[i]) <<< DATA_WIDTH) + DW'(r_pl[i]);
        end
        n_det = v_c[0] - v_c[1] + v_c[2];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 6; i++) begin
                r_p[i] <= n_p[i];
            end
            for (int i = 0; i < 3; i++) begin
                r_top_a[i] <= i_a[i];
                r_top_b[i] <= r_top_a[i];
                r_t[i]     <= n_t[i];
                r_pl[i]    <= n_pl[i];
                r_ph[i]    <= n_ph[i];
            end
            r_det <= n_det;
        end
    end

    assign o_det = r_det;

endmodule

[rtl/core/sc3_sing.sv]
// Tolerance product: tolerance fraction times the sum of squared entries.
module sc3_sing #(
    parameter int DATA_WIDTH = sc3_pkg::DATA_WIDTH_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_en,
    input  logic signed [DATA_WIDTH-1:0]                  i_a [sc3_pkg::N_ENTRIES],
    input  logic [sc3_pkg::TOL_W-1:0]                     i_tol_frac,
    output logic [sc3_pkg::TOL_W+2*DATA_WIDTH+1:0]        o_tol_prod
);

    localparam int P2W = 2 * DATA_WIDTH;
    localparam int SW  = P2W + 2;
    localparam int TPW = sc3_pkg::TOL_W + SW;
    localparam int SLW = SW / 2;
    localparam int SHW = SW - SLW;
    localparam int FLW = sc3_pkg::TOL_W / 2;
    localparam int FHW = sc3_pkg::TOL_W - FLW;
    localparam int PPW = FHW + SHW;

    logic signed [P2W-1:0] n_sq [sc3_pkg::N_ENTRIES];
    logic [P2W-1:0]        r_sq [sc3_pkg::N_ENTRIES];
    logic [SW-1:0]         r_sum;
    logic [SW-1:0]         n_sum;
    logic [PPW-1:0]        r_pp [4];
    logic [PPW-1:0]        n_pp [4];
    logic [TPW-1:0]        r_prod;
    logic [TPW-1:0]        n_prod;

    always_comb begin
        for (int i = 0; i < sc3_pkg::N_ENTRIES; i++) begin
            n_sq[i] = P2W'(i_a[i]) * P2W'(i_a[i]);
        end
        n_sum = (SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]))
              + (SW'(r_sq[3]) + SW'(r_sq[4]) + SW'(r_sq[5]))
              + (SW'(r_sq[6]) + SW'(r_sq[7]) + SW'(r_sq[8]));
        n_pp[0] = PPW'(i_tol_frac[FLW-1:0]) * PPW'(r_sum[SLW-1:0]);
        n_pp[1] = PPW'(i_tol_frac[FLW-1:0]) * PPW'(r_sum[SW-1:SLW]);
        n_pp[2] = PPW'(i_tol_frac[sc3_pkg::TOL_W-1:FLW]) * PPW'(r_sum[SLW-1:0]);
        n_pp[3] = PPW'(i_tol_frac[sc3_pkg::TOL_W-1:FLW]) * PPW'(r_sum[SW-1:SLW]);
        n_prod  = (TPW'(r_pp[0]) + (TPW'(r_pp[1]) << SLW))
                + ((TPW'(r_pp[2]) << FLW) + (TPW'(r_pp[3]) << (FLW + SLW)));
    end

    // The product is built from four partial products that are registered and then summed,
    // which also lines it up with the determinant lanes.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < sc3_pkg::N_ENTRIES; i++) begin
                r_sq[i] <= n_sq[i];
            end
            r_sum <= n_sum;
            for (int i = 0; i < 4; i++) begin
                r_pp[i] <= n_pp[i];
            end
            r_prod <= n_prod;
        end
    end

    assign o_tol_prod = r_prod;

endmodule

[rtl/core/sc3_div_lane.sv]
// One quotient lane: pipelined restoring divider, one quotient bit per stage, with clipping.
module sc3_div_lane #(
    parameter int DATA_WIDTH = sc3_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = sc3_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [3*DATA_WIDTH+2:0]      i_absd,
    input  logic [3*DATA_WIDTH+2:0]      i_absn,
    input  sc3_pkg::t_div_ctl            i_ctl,
    output logic signed [DATA_WIDTH-1:0] o_x,
    output logic                         o_sat
);

    localparam int W   = DATA_WIDTH;
    localparam int DW  = 3 * DATA_WIDTH + 3;
    localparam int NW  = DW + FRAC_BITS + 2;
    localparam int D2W = DW + 1;
    localparam int CW  = (NW > D2W + W) ? NW : D2W + W;

    logic [NW-1:0]      r_rem [W+1];
    logic [NW-1:0]      n_rem [W+1];
    logic [D2W-1:0]     r_d2  [W+1];
    logic [D2W-1:0]     n_d2  [W+1];
    logic [W-1:0]       r_q   [W+1];
    logic [W-1:0]       n_q   [W+1];
    logic               r_ovf [W+1];
    logic               n_ovf [W+1];
    sc3_pkg::t_div_ctl  r_ctl [W+1];
    sc3_pkg::t_div_ctl  n_ctl [W+1];
    logic [W-1:0]       r_x;
    logic [W-1:0]       n_x;
    logic               r_sat;
    logic               n_sat;

    logic [CW-1:0]      v_sub;
    logic [W-1:0]       v_lim;
    logic [W-1:0]       v_mag;
    logic               v_over;

    always_comb begin
        // Rounded quotient: (|N| * 2^(F+1) + |D|) / (2 |D|).
        n_rem[0] = (NW'(i_absn) << (FRAC_BITS + 1)) + NW'(i_absd);
        n_d2[0]  = {i_absd, 1'b0};
        n_ovf[0] = CW'(n_rem[0]) >= (CW'(n_d2[0]) << W);
        n_q[0]   = '0;
        n_ctl[0] = i_ctl;
        for (int k = 1; k <= W; k++) begin
            v_sub    = CW'(r_d2[k-1]) << (W - k);
            n_d2[k]  = r_d2[k-1];
            n_ovf[k] = r_ovf[k-1];
            n_ctl[k] = r_ctl[k-1];
            if (CW'(r_rem[k-1]) >= v_sub) begin
                n_rem[k] = NW'(CW'(r_rem[k-1]) - v_sub);
                n_q[k]   = r_q[k-1] | (W'(1) << (W - k));
            end else begin
                n_rem[k] = r_rem[k-1];
                n_q[k]   = r_q[k-1];
            end
        end

        v_lim  = r_ctl[W].neg ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
        v_over = r_ovf[W] || (r_q[W] > v_lim);
        v_mag  = v_over ? v_lim : r_q[W];
        if (r_ctl[W].sing) begin
            n_x   = '0;
            n_sat = 1'b0;
        end else begin
            n_x   = r_ctl[W].neg ? (W'(0) - v_mag) : v_mag;
            n_sat = v_over;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= W; k++) begin
                r_rem[k] <= n_rem[k];
                r_d2[k]  <= n_d2[k];
                r_q[k]   <= n_q[k];
                r_ovf[k] <= n_ovf[k];
                r_ctl[k] <= n_ctl[k];
            end
            r_x   <= n_x;
            r_sat <= n_sat;
        end
    end

    assign o_x   = r_x;
    assign o_sat = r_sat;

endmodule

[rtl/core/solve_3x3_cramer.sv]
// Top level of the pipelined 3x3 linear solver by Cramer's rule.
// Takes one request per clock, unless the output stalls, and returns one result per
// request, in order, after it passes the determinant lanes, the merge stage and the
// quotient lanes, which produce one quotient bit per stage. Four lanes form the
// determinant and the three column-replaced determinants side by side; the merge stage
// judges singularity, rounds the determinant and feeds three divider lanes. The whole
// pipeline holds while a finished result waits at the output and is not taken.
module solve_3x3_cramer #(
    parameter int DATA_WIDTH = sc3_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = sc3_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sc3_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sc3_pkg::TOL_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [DATA_WIDTH-1:0]    i_m00,
    input  logic signed [DATA_WIDTH-1:0]    i_m01,
    input  logic signed [DATA_WIDTH-1:0]    i_m02,
    input  logic signed [DATA_WIDTH-1:0]    i_m10,
    input  logic signed [DATA_WIDTH-1:0]    i_m11,
    input  logic signed [DATA_WIDTH-1:0]    i_m12,
    input  logic signed [DATA_WIDTH-1:0]    i_m20,
    input  logic signed [DATA_WIDTH-1:0]    i_m21,
    input  logic signed [DATA_WIDTH-1:0]    i_m22,
    input  logic signed [DATA_WIDTH-1:0]    i_rhs0,
    input  logic signed [DATA_WIDTH-1:0]    i_rhs1,
    input  logic signed [DATA_WIDTH-1:0]    i_rhs2,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [DATA_WIDTH-1:0]    o_x0,
    output logic signed [DATA_WIDTH-1:0]    o_x1,
    output logic signed [DATA_WIDTH-1:0]    o_x2,
    output logic signed [DATA_WIDTH-1:0]    o_determinant,
    output logic                            o_solved,
    output logic                            o_saturated
);

    `include "solve_3x3_cramer_defines.svh"

    localparam int W        = DATA_WIDTH;
    localparam int DW       = 3 * DATA_WIDTH + 3;
    localparam int SW       = 2 * DATA_WIDTH + 2;
    localparam int TPW      = sc3_pkg::TOL_W + SW;
    localparam int CMPW     = (DW + sc3_pkg::TOL_W > TPW + FRAC_BITS) ?
                              DW + sc3_pkg::TOL_W : TPW + FRAC_BITS;
    localparam int DIV_LAT  = DATA_WIDTH + 2;
    localparam int PIPE_LAT = sc3_pkg::DET_LAT + 1 + DIV_LAT;
    localparam logic [DW:0] HALF_DET = (DW + 1)'(1) << (2 * FRAC_BITS - 1);

    logic                        r_tol_en;
    logic [sc3_pkg::TOL_W-1:0]   r_tol_frac;
    logic [PIPE_LAT-1:0]         r_vld;
    logic                        w_adv;

    logic signed [W-1:0]  w_mat [sc3_pkg::N_ENTRIES];
    logic signed [W-1:0]  w_rhs [sc3_pkg::N_UNK];
    logic signed [W-1:0]  w_lane_a [sc3_pkg::N_LANES][sc3_pkg::N_ENTRIES];
    logic signed [DW-1:0] w_det [sc3_pkg::N_LANES];
    logic [TPW-1:0]       w_tol_prod;

    // Merge stage.
    logic [DW-1:0]              n_m_absd;
    logic [DW-1:0]              n_m_absn [sc3_pkg::N_UNK];
    sc3_pkg::t_div_ctl          n_m_ctl  [sc3_pkg::N_UNK];
    logic [W-1:0]               n_m_det;
    logic                       n_m_dsat;
    logic                       n_m_sing;
    logic [DW-1:0]              r_m_absd;
    logic [DW-1:0]              r_m_absn [sc3_pkg::N_UNK];
    sc3_pkg::t_div_ctl          r_m_ctl  [sc3_pkg::N_UNK];
    logic [W-1:0]               r_m_det;
    logic                       r_m_dsat;
    logic                       r_m_sing;

    logic                       v_negd;
    logic                       v_negn;
    logic [CMPW-1:0]            v_lhs;
    logic [CMPW-1:0]            v_rhs;
    logic [DW:0]                v_rnd;
    logic [DW:0]                v_lim;
    logic [DW:0]                v_mag;

    logic [W-1:0]               r_dl_det  [DIV_LAT];
    logic                       r_dl_dsat [DIV_LAT];
    logic                       r_dl_sing [DIV_LAT];

    logic signed [W-1:0]        w_x    [sc3_pkg::N_UNK];
    logic                       w_xsat [sc3_pkg::N_UNK];

    assign w_adv      = !r_vld[PIPE_LAT-1] || i_out_ready;
    assign o_in_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol_en   <= sc3_pkg::TOL_EN_RST;
            r_tol_frac <= sc3_pkg::TOL_FRAC_RST;
        end else if (i_cfg_we) begin
            case (sc3_pkg::t_cfg_idx'(i_cfg_index))
                sc3_pkg::CFG_TOL_ENABLE: begin
                    r_tol_en <= i_cfg_data[0];
                end
                sc3_pkg::CFG_TOL_FRACTION: begin
                    r_tol_frac <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_in_valid};
        end
    end

    // Lane 0 sees the matrix itself; lane j+1 has column j replaced by the right-hand side.
    always_comb begin
        w_mat[0] = i_m00; w_mat[1] = i_m01; w_mat[2] = i_m02;
        w_mat[3] = i_m10; w_mat[4] = i_m11; w_mat[5] = i_m12;
        w_mat[6] = i_m20; w_mat[7] = i_m21; w_mat[8] = i_m22;
        w_rhs[0] = i_rhs0; w_rhs[1] = i_rhs1; w_rhs[2] = i_rhs2;
        for (int l = 0; l < sc3_pkg::N_LANES; l++) begin
            for (int e = 0; e < sc3_pkg::N_ENTRIES; e++) begin
                w_lane_a[l][e] = w_mat[e];
            end
        end
        for (int l = 1; l < sc3_pkg::N_LANES; l++) begin
            for (int r = 0; r < sc3_pkg::N_UNK; r++) begin
                w_lane_a[l][3*r + l - 1] = w_rhs[r];
            end
        end
    end

    for (genvar j = 0; j < sc3_pkg::N_LANES; j++) begin : g_det
        sc3_det_lane #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_det (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_a   (w_lane_a[j]),
            .o_det (w_det[j])
        );
    end

    sc3_sing #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_sing (
        .i_clk      (i_clk),
        .i_en       (w_adv),
        .i_a        (w_mat),
        .i_tol_frac (r_tol_frac),
        .o_tol_prod (w_tol_prod)
    );

    always_comb begin
        v_negd   = w_det[0][DW-1];
        n_m_absd = v_negd ? DW'(-w_det[0]) : DW'(w_det[0]);
        // Relative test: |D| * 2^48 against t * S * 2^F.
        v_lhs    = CMPW'(n_m_absd) << sc3_pkg::TOL_W;
        v_rhs    = CMPW'(w_tol_prod) << FRAC_BITS;
        n_m_sing = (w_det[0] == '0) || (r_tol_en && (v_lhs < v_rhs));
        for (int j = 0; j < sc3_pkg::N_UNK; j++) begin
            v_negn           = w_det[j+1][DW-1];
            n_m_absn[j]      = v_negn ? DW'(-w_det[j+1]) : DW'(w_det[j+1]);
            n_m_ctl[j].neg   = v_negn ^ v_negd;
            n_m_ctl[j].sing  = n_m_sing;
        end
        // The determinant carries 3F fraction bits; round half away from zero to F.
        v_rnd    = ({1'b0, n_m_absd} + HALF_DET) >> (2 * FRAC_BITS);
        v_lim    = v_negd ? ((DW + 1)'(1) << (W - 1)) : (((DW + 1)'(1) << (W - 1)) - 1'b1);
        n_m_dsat = v_rnd > v_lim;
        v_mag    = n_m_dsat ? v_lim : v_rnd;
        n_m_det  = v_negd ? (W'(0) - v_mag[W-1:0]) : v_mag[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m_absd <= n_m_absd;
            for (int j = 0; j < sc3_pkg::N_UNK; j++) begin
                r_m_absn[j] <= n_m_absn[j];
                r_m_ctl[j]  <= n_m_ctl[j];
            end
            r_m_det  <= n_m_det;
            r_m_dsat <= n_m_dsat;
            r_m_sing <= n_m_sing;

            r_dl_det[0]  <= r_m_det;
            r_dl_dsat[0] <= r_m_dsat;
            r_dl_sing[0] <= r_m_sing;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_dl_det[k]  <= r_dl_det[k-1];
                r_dl_dsat[k] <= r_dl_dsat[k-1];
                r_dl_sing[k] <= r_dl_sing[k-1];
            end
        end
    end

    for (genvar j = 0; j < sc3_pkg::N_UNK; j++) begin : g_div
        sc3_div_lane #(
            .DATA_WIDTH(DATA_WIDTH),
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_absd (r_m_absd),
            .i_absn (r_m_absn[j]),
            .i_ctl  (r_m_ctl[j]),
            .o_x    (w_x[j]),
            .o_sat  (w_xsat[j])
        );
    end

    assign o_out_valid   = r_vld[PIPE_LAT-1];
    assign o_x0          = w_x[0];
    assign o_x1          = w_x[1];
    assign o_x2          = w_x[2];
    assign o_determinant = r_dl_det[DIV_LAT-1];
    assign o_solved      = !r_dl_sing[DIV_LAT-1];
    assign o_saturated   = r_dl_dsat[DIV_LAT-1] || w_xsat[0] || w_xsat[1] || w_xsat[2];

    `SC3_ASSERT_IMP(a_singular_zero_x, o_out_valid && !o_solved,
        o_x0 == '0 && o_x1 == '0 && o_x2 == '0, "singular result with nonzero unknowns")
    `SC3_ASSERT_IMP(a_stall_blocks_input, o_out_valid && !i_out_ready, !o_in_ready,
        "request taken while the output result is held")
    `SC3_ASSERT_NEXT(a_drain_empties, o_out_valid && i_out_ready && !r_vld[PIPE_LAT-2],
        !o_out_valid, "result appeared with no request behind it")

endmodule

[dv/solve_3x3_cramer_tb.sv]
// Self-checking testbench for the pipelined 3x3 Cramer's rule solver.
module solve_3x3_cramer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] ONE     = 32'h0001_0000;
    localparam logic [31:0] MAXV    = 32'h7FFF_FFFF;
    localparam logic [31:0] MINV    = 32'h8000_0000;
    localparam int          LIMIT   = 600000;
    localparam int          DRAIN   = 60;
    localparam int          LONG_HOLD = 300;

    typedef logic signed [255:0] t_wide;
    typedef logic [0:11][31:0] t_system;

    typedef struct packed {
        logic [31:0] x0;
        logic [31:0] x1;
        logic [31:0] x2;
        logic [31:0] det;
        logic        solved;
        logic        sat;
    } t_solution;

    typedef struct packed {
        t_system   sys;
        logic      known;
        t_solution res;
    } t_vector;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    sc3_pkg::t_cfg_idx             cfg_index = sc3_pkg::CFG_TOL_ENABLE;
    logic [sc3_pkg::TOL_W-1:0]     cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    t_system                       in_sys = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [31:0]                   o_x0, o_x1, o_x2, o_det;
    logic                          o_solved, o_sat;

    // Local copy of the two registers.
    logic                          tol_en = sc3_pkg::TOL_EN_RST;
    logic [sc3_pkg::TOL_W-1:0]     tol_frac = sc3_pkg::TOL_FRAC_RST;

    t_solution             pending[$];
    int                    errors = 0;
    int                    cycles = 0;
    int                    idle_pct = 0;
    int                    stall_pct = 0;
    int                    hold_req = 0;
    int                    hold_done = 0;
    int                    hold_left = 0;

    solve_3x3_cramer i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_m00(in_sys[0]), .i_m01(in_sys[1]), .i_m02(in_sys[2]),
        .i_m10(in_sys[3]), .i_m11(in_sys[4]), .i_m12(in_sys[5]),
        .i_m20(in_sys[6]), .i_m21(in_sys[7]), .i_m22(in_sys[8]),
        .i_rhs0(in_sys[9]), .i_rhs1(in_sys[10]), .i_rhs2(in_sys[11]),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_x0(o_x0), .o_x1(o_x1), .o_x2(o_x2), .o_determinant(o_det),
        .o_solved(o_solved), .o_saturated(o_sat)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_wide det3(input t_wide e[9]);
        t_wide t0, t1, t2;
        t0 = e[4] * e[8] - e[5] * e[7];
        t1 = e[3] * e[8] - e[5] * e[6];
        t2 = e[3] * e[7] - e[4] * e[6];
        return e[0] * t0 - e[1] * t1 + e[2] * t2;
    endfunction

    // Returns {clipped, value}.
    function automatic logic [32:0] clip32(input logic [255:0] mag, input logic neg);
        logic [255:0] lim;
        logic         over;
        lim = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
        over = mag > lim;
        if (over) mag = lim;
        return {over, neg ? -mag[31:0] : mag[31:0]};
    endfunction

    function automatic t_solution solve_system(input t_system sys);
        t_wide        a[9], c[9], r[3];
        t_wide        d, n, s;
        logic [255:0] magd, magn, num, lhs, rhs;
        logic         negd, negn, singular, sat;
        logic [32:0]  cl;
        logic [31:0]  xs[3];
        t_solution    res;
        for (int i = 0; i < 9; i++) a[i] = {{224{sys[i][31]}}, sys[i]};
        for (int i = 0; i < 3; i++) r[i] = {{224{sys[9+i][31]}}, sys[9+i]};
        d = det3(a);
        negd = d[255];
        magd = negd ? -d : d;
        s = '0;
        for (int i = 0; i < 9; i++) s = s + a[i] * a[i];
        singular = (d == 0);
        if (!singular && tol_en) begin
            lhs = magd << 48;
            rhs = ({208'b0, tol_frac} * s) << 16;
            singular = lhs < rhs;
        end
        cl = clip32((magd + (256'd1 << 31)) >> 32, negd);
        sat = cl[32];
        res.det = cl[31:0];
        for (int i = 0; i < 3; i++) begin
            xs[i] = '0;
            if (!singular) begin
                c = a;
                c[i] = r[0];
                c[3+i] = r[1];
                c[6+i] = r[2];
                n = det3(c);
                negn = n[255];
                magn = negn ? -n : n;
                num = (magn << 17) + magd;
                cl = clip32(num / (magd << 1), negn != negd);
                sat = sat | cl[32];
                xs[i] = cl[31:0];
            end
        end
        res.x0 = xs[0];
        res.x1 = xs[1];
        res.x2 = xs[2];
        res.solved = !singular;
        res.sat = sat;
        return res;
    endfunction

    function automatic logic [31:0] pick_value(input int kind);
        case (kind)
            0: return $urandom;
            1: return 32'($urandom_range(0, 2 ** 19)) - 32'(2 ** 18);
            2: return 32'($urandom_range(0, 64)) - 32'd32;
            default: begin
                case ($urandom_range(5))
                    0: return MAXV;
                    1: return MINV;
                    2: return '0;
                    3: return 32'hFFFF_FFFF;
                    4: return ONE;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    function automatic t_system random_system();
        t_system sys;
        int      shape, kind;
        shape = $urandom_range(9);
        kind = (shape <= 1) ? 0 : (shape <= 5) ? 1 : (shape == 9) ? 3 : 1;
        for (int i = 0; i < 12; i++) sys[i] = pick_value(kind);
        case (shape)
            6: for (int j = 0; j < 3; j++)
                   sys[6+j] = sys[j] + sys[3+j] + pick_value(2);
            7: for (int j = 0; j < 3; j++) sys[6+j] = sys[3+j];
            8: begin
                // Strongly diagonal system with a large spread of magnitudes.
                for (int i = 0; i < 9; i++) sys[i] = pick_value(2);
                sys[0] = pick_value(0);
                sys[4] = pick_value(0);
                sys[8] = pick_value(0);
            end
            default: ;
        endcase
        return sys;
    endfunction

    task automatic write_reg(input sc3_pkg::t_cfg_idx idx,
                             input logic [sc3_pkg::TOL_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == sc3_pkg::CFG_TOL_ENABLE) tol_en = value[0];
        else tol_frac = value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic send_request(input t_system sys, input logic known, input t_solution res);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_sys <= sys;
        do @(posedge i_clk); while (!in_ready);
        pending.push_back(known ? res : solve_system(sys));
    endtask

    task automatic report(input string what, input t_solution want, input t_solution got);
        errors++;
        if (errors <= 10)
            $display("%s: x0 %h/%h x1 %h/%h x2 %h/%h det %h/%h solved %b/%b sat %b/%b",
                     what, want.x0, got.x0, want.x1, got.x1, want.x2, got.x2,
                     want.det, got.det, want.solved, got.solved, want.sat, got.sat);
    endtask

    // Result receiver: random stalls plus an occasional long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (hold_req != hold_done) begin
            hold_done <= hold_req;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_solution got, want;
        if (i_rst_n && out_valid && out_ready) begin
            got = '{o_x0, o_x1, o_x2, o_det, o_solved, o_sat};
            if (pending.size() == 0) begin
                report("unexpected result", '0, got);
            end else begin
                want = pending.pop_front();
                if (got.x0 !== want.x0 || got.x1 !== want.x1 || got.x2 !== want.x2 ||
                    got.det !== want.det || got.solved !== want.solved ||
                    got.sat !== want.sat)
                    report("mismatch (expected/actual)", want, got);
            end
        end
    end

    t_vector directed[] = '{
        '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 1'b0, 1'b0}},
        '{'{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, ONE, 32'hFFFD_8000, 32'h0003_0000},
          1'b1, '{ONE, 32'hFFFD_8000, 32'h0003_0000, ONE, 1'b1, 1'b0}},
        '{'{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, MAXV, MINV, 0},
          1'b1, '{MAXV, MINV, 0, ONE, 1'b1, 1'b0}},
        '{'{MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV, 0, 0, 0}, 1'b1, '{0, 0, 0, MAXV, 1'b1, 1'b1}},
        '{'{MINV, 0, 0, 0, MINV, 0, 0, 0, MINV, 0, 0, 0}, 1'b1, '{0, 0, 0, MINV, 1'b1, 1'b1}},
        '{'{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV},
          1'b1, '{0, 0, 0, 0, 1'b0, 1'b0}},
        '{'{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV},
          1'b1, '{0, 0, 0, 0, 1'b0, 1'b0}},
        '{'{32'h8000, 0, 0, 0, 32'h8000, 0, 0, 0, 32'h8000, MAXV, MAXV, MAXV},
          1'b1, '{MAXV, MAXV, MAXV, 32'h2000, 1'b1, 1'b1}},
        // Third row is the sum of the first two, so the determinant is exactly zero.
        '{'{ONE, 32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000, ONE, 32'h0003_0000,
            32'h0001_8000, 32'h0003_0000, 32'h0002_0000, ONE, ONE, ONE},
          1'b1, '{0, 0, 0, 0, 1'b0, 1'b0}},
        // Determinant far below one LSB.
        '{'{1, 0, 0, 0, 1, 0, 0, 0, 1, 1, 32'hFFFF_FFFF, 2}, 1'b0, '0},
        // Nearly singular against the size of the entries.
        '{'{32'h4000_0000, 32'h4000_0000, 0, 32'h4000_0000, 32'h4000_0001, 0,
            0, 0, 1, ONE, 32'h0002_0000, 32'h0003_0000}, 1'b0, '0},
        '{'{ONE, 0, 0, 0, ONE, 0, 0, 0, 1, ONE, ONE, ONE}, 1'b0, '0},
        '{'{0, ONE, 0, 0, 0, 32'hFFFF_0000, ONE, 0, 0, 32'h0001_4000, 32'h7FFF_0000,
            32'hFFFF_FFFF}, 1'b0, '0},
        '{'{32'h0002_0000, 32'hFFFF_0000, 32'h0000_4000, 32'h0003_8000, 32'h0001_0001,
            32'hFFFE_0000, 32'h0000_0003, 32'h0005_0000, 32'hFFFF_FFFF,
            32'h0001_2345, 32'hFFF0_0000, 32'h0000_0001}, 1'b0, '0},
        '{'{32'hFFFF_FFFF, MAXV, MINV, 1, 32'hFFFF_FFFF, ONE, MAXV, 0, MINV,
            MINV, MAXV, 32'hFFFF_FFFF}, 1'b0, '0}
    };

    initial begin
        logic [sc3_pkg::TOL_W-1:0] frac_pick;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) send_request(directed[k].sys, directed[k].known, directed[k].res);
        wait_drained();

        for (int p = 0; p < 5; p++) begin
            case (p)
                1: write_reg(sc3_pkg::CFG_TOL_ENABLE, 48'd0);
                2: begin
                    write_reg(sc3_pkg::CFG_TOL_ENABLE, 48'd1);
                    write_reg(sc3_pkg::CFG_TOL_FRACTION, {sc3_pkg::TOL_W{1'b1}});
                end
                3: write_reg(sc3_pkg::CFG_TOL_FRACTION, '0);
                4: begin
                    frac_pick = sc3_pkg::TOL_W'({$urandom, $urandom} >>
                                                $urandom_range(16, 47));
                    write_reg(sc3_pkg::CFG_TOL_FRACTION, frac_pick);
                end
                default: ;
            endcase
            for (int q = 0; q < 4; q++) begin
                idle_pct = (q == 1) ? 57 : (q == 3) ? 19 : 0;
                stall_pct = (q == 2) ? 57 : (q == 3) ? 19 : 0;
                for (int k = 0; k < 72; k++) begin
                    // Hold the receiver off long enough for the input to back up.
                    if (p == 1 && q == 0 && k == 10) hold_req++;
                    // Let everything in flight arrive before going on.
                    if (p == 2 && q == 1 && k == 30) begin
                        in_valid <= 1'b0;
                        while (pending.size() != 0) @(posedge i_clk);
                    end
                    send_request(random_system(), 1'b0, '0);
                end
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[solve_3x3_cramer.f]
+incdir+rtl/core
rtl/core/sc3_pkg.sv
rtl/core/sc3_det_lane.sv
rtl/core/sc3_sing.sv
rtl/core/sc3_div_lane.sv
rtl/core/solve_3x3_cramer.sv
dv/solve_3x3_cramer_tb.sv
